FILE: hdl/cpsq_pkg.sv
// Shared types and constants for the credit-paced send queue.
// No dependencies; used by credit_paced_send_queue_unit.
package cpsq_pkg;

	// request function codes
	localparam logic [1:0] FUNC_ENQ_NORMAL = 2'd0;
	localparam logic [1:0] FUNC_ENQ_PRIO   = 2'd1;
	localparam logic [1:0] FUNC_TICK       = 2'd2;
	localparam logic [1:0] FUNC_STOP       = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_SENT     = 2'd0;
	localparam logic [1:0] KIND_PING     = 2'd1;
	localparam logic [1:0] KIND_SHUTDOWN = 2'd2;
	localparam logic [1:0] KIND_DROPPED  = 2'd3;

	// register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_CREDIT_CAP  = 2'd0;
	localparam logic [1:0] REG_CREDIT_COST = 2'd1;
	localparam logic [1:0] REG_PING_PERIOD = 2'd2;

	localparam int CREDIT_BITS = 4;
	localparam int PERIOD_BITS = 8;
	localparam int SEND_BITS   = 4;
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [CREDIT_BITS-1:0] CREDIT_CAP_RST  = 4'd8;
	localparam logic [CREDIT_BITS-1:0] CREDIT_COST_RST = 4'd2;
	localparam logic [PERIOD_BITS-1:0] PING_PERIOD_RST = 8'd60;

	// most messages sent on one tick
	localparam logic [SEND_BITS-1:0] MAX_SENDS = 4'd15;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

FILE: hdl/credit_paced_send_queue_unit.sv
// Credit-paced send queue: handle deque, credit refill, keepalive and shutdown.
// Depends on cpsq_pkg (types, codes, reset values).
//
// Usage: requests (func, msg_handle) come in on req_valid/req_stall, results
// (kind, sent_handle, last) leave on rsp_valid/rsp_stall. The block stalls
// requests while it works on one. An enqueue that fits gives no result. A
// full queue gives a drop result: the block takes the request, then loads
// the output register.
// A tick refills credit, then drains the queue through one sequencer loop
// around a single credit subtract/compare unit and the queue memory read port:
// it takes the tick, then for each message sent it checks, reads the memory
// and loads the output register. A tick that finds messages but cannot send
// one ends at the check; one that pings or shuts down loads the output register.
// Each sent message needs one free slot in the output register: a stalled
// receiver holds the sequencer in its emit step, so nothing is lost.
// The last result of each request has last set.
// Reset: queue empty, credit 8, countdown 60, cap 8, cost 2, period 60,
// not stopped. After shutdown, every request is taken and ignored.
// Configuration is an APB-style port, registers at byte 0, 4 and 8.
module credit_paced_send_queue_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        func,
	input  logic [HANDLE_BITS-1:0]            msg_handle,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [1:0]                        kind,
	output logic [HANDLE_BITS-1:0]            sent_handle,
	output logic                              last,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cpsq_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [cpsq_pkg::DATA_BITS-1:0]    pwdata,
	output logic [cpsq_pkg::DATA_BITS-1:0]    prdata,
	output logic                              pready
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_BITS = PTR_BITS + 1;
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);
	localparam logic [SUM_BITS-1:0] DEPTH_SUM = SUM_BITS'(QUEUE_DEPTH);

	localparam int CB = cpsq_pkg::CREDIT_BITS;
	localparam int PB = cpsq_pkg::PERIOD_BITS;
	localparam int SB = cpsq_pkg::SEND_BITS;

	cpsq_pkg::state_t state_q;

	logic [CB-1:0]          cap_q, cost_q, credit_q;
	logic [PB-1:0]          period_q, countdown_q;
	logic [PTR_BITS-1:0]    head_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [SB-1:0]          sends_q;
	logic                   stop_q, halted_q;
	logic [HANDLE_BITS-1:0] rd_q;

	logic [1:0]             pend_kind_q;
	logic [HANDLE_BITS-1:0] pend_handle_q;
	logic                   pend_last_q;

	logic                   rsp_valid_q, last_q;
	logic [1:0]             kind_q;
	logic [HANDLE_BITS-1:0] sent_handle_q;

	logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];

	logic                   req_xfer, rsp_xfer, cfg_wr, out_free;
	logic                   is_enq, q_full, wr_en;
	logic [PTR_BITS-1:0]    wr_addr, head_dec;
	logic [SUM_BITS-1:0]    tail_sum;
	logic [CB-1:0]          credit_inc, credit_sub;
	logic [PB-1:0]          countdown_dec;
	logic                   can_send, more_after;
	logic [CNT_BITS-1:0]    count_dec;
	logic [SB-1:0]          sends_inc;

	assign req_stall = (state_q != cpsq_pkg::ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	assign rsp_valid   = rsp_valid_q;
	assign kind        = kind_q;
	assign sent_handle = sent_handle_q;
	assign last        = last_q;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			cpsq_pkg::REG_CREDIT_CAP:  prdata = cpsq_pkg::DATA_BITS'(cap_q);
			cpsq_pkg::REG_CREDIT_COST: prdata = cpsq_pkg::DATA_BITS'(cost_q);
			cpsq_pkg::REG_PING_PERIOD: prdata = cpsq_pkg::DATA_BITS'(period_q);
			default:                   prdata = '0;
		endcase
	end

	// enqueue address: front slot for priority, head+count (mod depth) for normal
	assign is_enq   = (func == cpsq_pkg::FUNC_ENQ_NORMAL) || (func == cpsq_pkg::FUNC_ENQ_PRIO);
	assign q_full   = (count_q == FULL_CNT);
	assign head_dec = (head_q == '0) ? LAST_PTR : head_q - 1'b1;
	assign tail_sum = SUM_BITS'(head_q) + SUM_BITS'(count_q);
	always_comb begin
		if (tail_sum >= DEPTH_SUM)
			wr_addr = PTR_BITS'(tail_sum - DEPTH_SUM);
		else
			wr_addr = PTR_BITS'(tail_sum);
		if (func == cpsq_pkg::FUNC_ENQ_PRIO)
			wr_addr = head_dec;
	end
	assign wr_en = req_xfer && !halted_q && is_enq && !q_full;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= msg_handle;
		rd_q <= mem[head_q];
	end

	// shared credit unit: refill on tick, subtract and compare in the send loop
	assign credit_inc    = (credit_q < cap_q) ? credit_q + 1'b1 : credit_q;
	assign credit_sub    = credit_q - cost_q;
	assign countdown_dec = countdown_q - 1'b1;
	assign count_dec     = count_q - 1'b1;
	assign sends_inc     = sends_q + 1'b1;
	assign can_send      = (count_q != '0) && (credit_q >= cost_q)
		&& (sends_q < cpsq_pkg::MAX_SENDS);
	assign more_after    = (count_dec != '0) && (credit_sub >= cost_q)
		&& (sends_inc < cpsq_pkg::MAX_SENDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= cpsq_pkg::CREDIT_CAP_RST;
			cost_q   <= cpsq_pkg::CREDIT_COST_RST;
			period_q <= cpsq_pkg::PING_PERIOD_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				cpsq_pkg::REG_CREDIT_CAP:  cap_q    <= pwdata[CB-1:0];
				cpsq_pkg::REG_CREDIT_COST: cost_q   <= pwdata[CB-1:0];
				cpsq_pkg::REG_PING_PERIOD: period_q <= pwdata[PB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpsq_pkg::ST_IDLE;
			credit_q    <= cpsq_pkg::CREDIT_CAP_RST;
			countdown_q <= cpsq_pkg::PING_PERIOD_RST;
			head_q      <= '0;
			count_q     <= '0;
			sends_q     <= '0;
			stop_q      <= 1'b0;
			halted_q    <= 1'b0;
		end else begin
			unique case (state_q)
				cpsq_pkg::ST_IDLE: begin
					if (req_xfer && !halted_q) begin
						case (func) inside
							cpsq_pkg::FUNC_ENQ_NORMAL, cpsq_pkg::FUNC_ENQ_PRIO: begin
								if (q_full) begin
									state_q <= cpsq_pkg::ST_EMIT;
								end else begin
									count_q <= count_q + 1'b1;
									if (func == cpsq_pkg::FUNC_ENQ_PRIO)
										head_q <= head_dec;
								end
							end
							cpsq_pkg::FUNC_TICK: begin
								credit_q <= credit_inc;
								sends_q  <= '0;
								if (count_q != '0) begin
									countdown_q <= period_q;
									state_q     <= cpsq_pkg::ST_CHECK;
								end else if (stop_q) begin
									halted_q <= 1'b1;
									state_q  <= cpsq_pkg::ST_EMIT;
								end else if (countdown_dec == '0) begin
									countdown_q <= period_q;
									state_q     <= cpsq_pkg::ST_EMIT;
								end else begin
									countdown_q <= countdown_dec;
								end
							end
							default: stop_q <= 1'b1;
						endcase
					end
				end
				cpsq_pkg::ST_CHECK: begin
					// rd_q picks up the current head at this edge
					if (can_send) begin
						head_q   <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
						count_q  <= count_dec;
						credit_q <= credit_sub;
						sends_q  <= sends_inc;
						state_q  <= cpsq_pkg::ST_FETCH;
					end else begin
						state_q <= cpsq_pkg::ST_IDLE;
					end
				end
				cpsq_pkg::ST_FETCH: state_q <= cpsq_pkg::ST_EMIT;
				cpsq_pkg::ST_EMIT: begin
					if (out_free)
						state_q <= pend_last_q ? cpsq_pkg::ST_IDLE : cpsq_pkg::ST_CHECK;
				end
				default: state_q <= cpsq_pkg::ST_IDLE;
			endcase
		end
	end

	// pending result, built by the sequencer before the output register
	always_ff @(posedge clk) begin
		if (state_q == cpsq_pkg::ST_IDLE && req_xfer) begin
			pend_last_q   <= 1'b1;
			pend_handle_q <= '0;
			if (is_enq) begin
				pend_kind_q   <= cpsq_pkg::KIND_DROPPED;
				pend_handle_q <= msg_handle;
			end else if (stop_q) begin
				pend_kind_q <= cpsq_pkg::KIND_SHUTDOWN;
			end else begin
				pend_kind_q <= cpsq_pkg::KIND_PING;
			end
		end else if (state_q == cpsq_pkg::ST_CHECK) begin
			pend_kind_q <= cpsq_pkg::KIND_SENT;
			pend_last_q <= !more_after;
		end else if (state_q == cpsq_pkg::ST_FETCH) begin
			pend_handle_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == cpsq_pkg::ST_EMIT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cpsq_pkg::ST_EMIT && out_free) begin
			kind_q        <= pend_kind_q;
			sent_handle_q <= pend_handle_q;
			last_q        <= pend_last_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count above depth");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared");

	a_send_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sends_q <= cpsq_pkg::MAX_SENDS)
		else $error("too many sends on one tick");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cpsq_pkg::ST_EMIT && out_free) |=> rsp_valid_q)
		else $error("emit step did not load the output register");

	a_send_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cpsq_pkg::ST_CHECK && can_send) |-> (count_q != '0))
		else $error("send from an empty queue");

endmodule
